>>> sv/fmns_pkg.sv
// Shared types, register indexes and constants for the Fibonacci-modulo note sequencer.
`timescale 1ns / 1ps
package fmns_pkg;

  localparam int PERIOD_BITS_DEF = 24;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SEED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_SEED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_NOTE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_COUNT  = 3'd6;

  localparam logic [23:0] STEP_PERIOD_RST = 24'd5512;
  localparam logic [6:0]  BASE_NOTE_RST   = 7'd60;
  localparam logic [6:0]  NOTE_COUNT_RST  = 7'd24;
  localparam logic [4:0]  FIRST_SEED_RST  = 5'd0;
  localparam logic [4:0]  SECOND_SEED_RST = 5'd1;
  localparam int          MIN_PERIOD      = 256;
  localparam logic [6:0]  NOTE_MAX        = 7'd127;
  localparam logic [2:0]  DIV_LAST_STEP   = 3'd7;

  typedef struct packed {
    logic take;
    logic start_div;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic fire;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> sv/fmns_ifs.sv
// Valid/ready channel interfaces for sample ticks and note-on results.
`timescale 1ns / 1ps
interface fmns_in_if;
  logic valid;
  logic ready;
  logic playing;
  modport source (output valid, output playing, input ready);
  modport sink (input valid, input playing, output ready);
endinterface

interface fmns_out_if;
  logic              valid;
  logic              ready;
  logic [6:0]        note;
  logic signed [7:0] residue;
  modport source (output valid, output note, output residue, input ready);
  modport sink (input valid, input note, input residue, output ready);
endinterface

>>> sv/fibonacci_mod_note_sequencer.sv
// Top level of the Fibonacci-modulo note sequencer.
// A tick that causes no note leaves the block ready; the next tick transfers in the following cycle.
// A tick that fires a note runs a transfer, 8 restoring remainder iterations and a load into
// the output register, held while an earlier result waits for out_ch.ready; the next tick
// transfers in the cycle after that load.
// Reset (synchronous, active low) restores register defaults, seeds and a zero countdown.
`timescale 1ns / 1ps
module fibonacci_mod_note_sequencer #(
  parameter int PERIOD_BITS = fmns_pkg::PERIOD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fmns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fmns_pkg::CFG_DATA_W-1:0] cfg_data,
  fmns_in_if.sink                         in_ch,
  fmns_out_if.source                      out_ch
);
  import fmns_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fmns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fmns_dpath #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_playing  (in_ch.playing),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_note    (out_ch.note),
    .out_residue (out_ch.residue)
  );

  a_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && stat.fire) |=> !in_ch.ready)
    else $error("ready while a note is in progress");

  a_quiet_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !stat.fire) |=> in_ch.ready)
    else $error("tick without a note left the block busy");

  a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.residue != -8'sd128))
    else $error("residue out of range");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("result loaded over a pending one");

endmodule

>>> sv/fmns_ctrl.sv
// Controller state machine: tick transfer, remainder iterations and result hand-off.
`timescale 1ns / 1ps
module fmns_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fmns_pkg::dp_stat_t stat,
  output fmns_pkg::dp_cmd_t  cmd
);
  import fmns_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.fire) begin
            cmd.start_div = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/fmns_dpath.sv
// Datapath: registers, countdown, recurrence state, serial remainder and output register.
`timescale 1ns / 1ps
module fmns_dpath #(
  parameter int PERIOD_BITS = fmns_pkg::PERIOD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fmns_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fmns_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_playing,
  input  fmns_pkg::dp_cmd_t                cmd,
  output fmns_pkg::dp_stat_t               stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [6:0]                       out_note,
  output logic signed [7:0]                out_residue
);
  import fmns_pkg::*;

  localparam logic [32:0] PMAX = (33'd1 << PERIOD_BITS) - 33'd1;
  localparam logic [32:0] PMIN = 33'(MIN_PERIOD);

  logic                   sync_r, dir_r;
  logic [23:0]            period_r;
  logic [4:0]             seed1_r, seed2_r;
  logic [6:0]             base_r, nc_r;
  logic [PERIOD_BITS-1:0] cd_r, cd_nxt;
  logic [7:0]             older_r, older_nxt, newer_r, newer_nxt;
  logic                   running_r;
  logic [7:0]             dvd_r;
  logic [6:0]             rem_r;
  logic                   neg_r;
  logic [2:0]             cnt_r;
  logic                   out_valid_r;
  logic [6:0]             note_r;
  logic [7:0]             res_r;

  logic                   cfg_hit;
  logic [32:0]            step_ext, sat_val, ep_val;
  logic [PERIOD_BITS-1:0] ep;
  logic [6:0]             nc_eff;
  logic [4:0]             seed1_in, seed2_in;
  logic [7:0]             s1_ext, s2_ext, old_e, new_e;
  logic [PERIOD_BITS-1:0] cd_e;
  logic                   start_t, active;
  logic [8:0]             sum9, mag9;
  logic [7:0]             trial;
  logic                   ge;
  logic [7:0]             res_val;
  logic [9:0]             note10;
  logic [6:0]             note_val;

  always_comb begin
    case (cfg_index)
      REG_SYNC_MODE, REG_STEP_PERIOD, REG_DIRECTION, REG_FIRST_SEED,
      REG_SECOND_SEED, REG_BASE_NOTE, REG_NOTE_COUNT: cfg_hit = cfg_we;
      default: cfg_hit = 1'b0;
    endcase
  end

  assign step_ext = 33'(period_r);
  assign sat_val  = (step_ext > PMAX) ? PMAX : step_ext;
  assign ep_val   = (sat_val < PMIN) ? PMIN : sat_val;
  assign ep       = ep_val[PERIOD_BITS-1:0];
  assign nc_eff   = (nc_r == 7'd0) ? 7'd1 : nc_r;

  assign seed1_in = (cfg_we && cfg_index == REG_FIRST_SEED) ? cfg_data[4:0] : seed1_r;
  assign seed2_in = (cfg_we && cfg_index == REG_SECOND_SEED) ? cfg_data[4:0] : seed2_r;
  assign s1_ext  = {{3{seed1_in[4]}}, seed1_in};
  assign s2_ext  = {{3{seed2_in[4]}}, seed2_in};
  assign start_t = in_playing && !running_r;
  assign old_e   = start_t ? s1_ext : older_r;
  assign new_e   = start_t ? s2_ext : newer_r;
  assign cd_e    = start_t ? '0 : cd_r;
  assign active  = !sync_r || in_playing;

  assign stat.fire     = active && (cd_e <= PERIOD_BITS'(1));
  assign stat.div_last = (cnt_r == DIV_LAST_STEP);
  assign stat.out_free = !out_valid_r || out_ready;

  assign sum9  = {old_e[7], old_e} + {new_e[7], new_e};
  assign mag9  = sum9[8] ? (9'd0 - sum9) : sum9;
  assign trial = {rem_r, dvd_r[7]};
  assign ge    = trial >= {1'b0, nc_eff};

  assign res_val = neg_r ? (8'd0 - {1'b0, rem_r}) : {1'b0, rem_r};

  always_comb begin
    if (dir_r) begin
      note10 = {3'd0, base_r} + {3'd0, nc_eff} - 10'd1 - {{2{res_val[7]}}, res_val};
    end else begin
      note10 = {3'd0, base_r} + {{2{res_val[7]}}, res_val};
    end
    if (note10[9]) begin
      note_val = 7'd0;
    end else if (note10 > {3'd0, NOTE_MAX}) begin
      note_val = NOTE_MAX;
    end else begin
      note_val = note10[6:0];
    end
  end

  always_comb begin
    cd_nxt    = cd_r;
    older_nxt = older_r;
    newer_nxt = newer_r;
    if (cfg_hit) begin
      cd_nxt    = '0;
      older_nxt = s1_ext;
      newer_nxt = s2_ext;
    end else if (cmd.take) begin
      older_nxt = old_e;
      newer_nxt = new_e;
      cd_nxt    = cd_e;
      if (active) begin
        if (stat.fire) begin
          cd_nxt    = ep;
          older_nxt = new_e;
        end else begin
          cd_nxt = cd_e - PERIOD_BITS'(1);
        end
      end
    end else if (cmd.load_out) begin
      newer_nxt = res_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r      <= 1'b1;
      period_r    <= STEP_PERIOD_RST;
      dir_r       <= 1'b0;
      seed1_r     <= FIRST_SEED_RST;
      seed2_r     <= SECOND_SEED_RST;
      base_r      <= BASE_NOTE_RST;
      nc_r        <= NOTE_COUNT_RST;
      cd_r        <= '0;
      older_r     <= {{3{FIRST_SEED_RST[4]}}, FIRST_SEED_RST};
      newer_r     <= {{3{SECOND_SEED_RST[4]}}, SECOND_SEED_RST};
      running_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SYNC_MODE:   sync_r   <= cfg_data[0];
          REG_STEP_PERIOD: period_r <= cfg_data[23:0];
          REG_DIRECTION:   dir_r    <= cfg_data[0];
          REG_FIRST_SEED:  seed1_r  <= cfg_data[4:0];
          REG_SECOND_SEED: seed2_r  <= cfg_data[4:0];
          REG_BASE_NOTE:   base_r   <= cfg_data[6:0];
          REG_NOTE_COUNT:  nc_r     <= cfg_data[6:0];
          default: ;
        endcase
      end
      cd_r    <= cd_nxt;
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      if (cmd.take) begin
        running_r <= in_playing;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      dvd_r <= mag9[7:0];
      rem_r <= 7'd0;
      neg_r <= sum9[8];
      cnt_r <= 3'd0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[6:0], 1'b0};
      rem_r <= ge ? 7'(trial - {1'b0, nc_eff}) : trial[6:0];
      cnt_r <= cnt_r + 3'd1;
    end
    if (cmd.load_out) begin
      note_r <= note_val;
      res_r  <= res_val;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_note    = note_r;
  assign out_residue = $signed(res_r);

endmodule
